@@ rtl/core/lfr_pkg.sv @@
package lfr_pkg;

    // Frame store geometry and control table size
    localparam int FRAME_DEPTH     = 1024;
    localparam int CONTROL_ENTRIES = 4;
    localparam int WIDX_W          = $clog2(FRAME_DEPTH);
    localparam int CIDX_W          = 2;

    localparam logic [WIDX_W-1:0] HEADER_LEN = WIDX_W'(4);
    localparam logic [WIDX_W-1:0] WIDX_LAST  = WIDX_W'(FRAME_DEPTH - 1);

    // Receiver phase codes
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_FLAG  = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_CTRL  = 3'd3;
    localparam logic [2:0] PH_HDR   = 3'd4;
    localparam logic [2:0] PH_STOP  = 3'd5;

    // Configuration register indexes
    localparam logic [7:0] REG_FLAG    = 8'd0;
    localparam logic [7:0] REG_ADDRESS = 8'd1;
    localparam logic [7:0] REG_MODE    = 8'd2;
    localparam logic [7:0] REG_COUNT   = 8'd3;
    localparam logic [7:0] REG_CTRL_0  = 8'd4;
    localparam logic [7:0] REG_CTRL_1  = 8'd5;
    localparam logic [7:0] REG_CTRL_2  = 8'd6;
    localparam logic [7:0] REG_CTRL_3  = 8'd7;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [2:0]        rx_state;
        logic              store_enable;
        logic [WIDX_W-1:0] store_position;
        logic [7:0]        store_byte;
        logic              frame_done;
        logic [WIDX_W-1:0] payload_length;
        logic [CIDX_W-1:0] control_index;
        logic              overflow;
    } t_out;

    typedef struct packed {
        logic [7:0]                         flag_byte;
        logic [7:0]                         address_byte;
        logic                               frame_mode;
        logic [2:0]                         control_count;
        logic [CONTROL_ENTRIES-1:0][7:0]    control_byte;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        rx_phase;
        logic [WIDX_W-1:0] write_index;
        logic [7:0]        seen_address;
        logic [7:0]        seen_control;
        logic [CIDX_W-1:0] matched_index;
    } t_state;

endpackage

@@ rtl/core/link_frame_receiver.sv @@
// Each byte passes through the input register and then the result register before its
// result is offered.
// Throughput: one byte per cycle unless the result side stalls; the phase update and
// the parallel control table compare sit between the input register and the result register.
// Reset (synchronous, active low): both pipeline stages empty, receiver hunting for
// a flag with position zero, configuration registers at their documented defaults.
module link_frame_receiver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lfr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lfr_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);
    import lfr_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_out   step_result;

    logic   r_s1_valid;
    t_in    r_s1_data;
    logic   r_out_valid;
    t_out   r_out_data;
    logic   out_free;
    logic   s1_move;
    logic   in_take;

    assign o_cfg_ready = 1'b1;

    lfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lfr_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_s1_data),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in_data;
        end
    end

    // Receiver state advances as each byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_move) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A completed frame writes its closing flag and parks in stop
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done) |->
            (o_out_data.store_enable && o_out_data.rx_state == PH_STOP))
        else $error("frame done without store or stop phase");

    // A dropped frame returns to hunting and writes nothing
    a_ovf_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (!o_out_data.store_enable && o_out_data.rx_state == PH_START))
        else $error("overflow not returning to start");

    // No store write leaves position and byte at zero
    a_idle_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.store_enable) |->
            (o_out_data.store_position == '0 && o_out_data.store_byte == '0))
        else $error("store fields set without store write");

    // Receiver state only moves when a byte passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_move) |=> $stable(r_state))
        else $error("receiver state changed without a byte");

endmodule

@@ rtl/core/lfr_cfg.sv @@
module lfr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output lfr_pkg::t_cfg o_cfg
);
    import lfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index and update the addressed field
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FLAG:    n_cfg.flag_byte       = i_cfg_data;
                REG_ADDRESS: n_cfg.address_byte    = i_cfg_data;
                REG_MODE:    n_cfg.frame_mode      = i_cfg_data[0];
                REG_COUNT:   n_cfg.control_count   = i_cfg_data[2:0];
                REG_CTRL_0:  n_cfg.control_byte[0] = i_cfg_data;
                REG_CTRL_1:  n_cfg.control_byte[1] = i_cfg_data;
                REG_CTRL_2:  n_cfg.control_byte[2] = i_cfg_data;
                REG_CTRL_3:  n_cfg.control_byte[3] = i_cfg_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte       <= 8'd126;
            r_cfg.address_byte    <= 8'd3;
            r_cfg.frame_mode      <= 1'b0;
            r_cfg.control_count   <= 3'd1;
            r_cfg.control_byte[0] <= 8'd3;
            r_cfg.control_byte[1] <= 8'd0;
            r_cfg.control_byte[2] <= 8'd0;
            r_cfg.control_byte[3] <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/lfr_step.sv @@
module lfr_step (
    input  lfr_pkg::t_cfg   i_cfg,
    input  lfr_pkg::t_state i_state,
    input  lfr_pkg::t_in    i_item,
    output lfr_pkg::t_state o_state,
    output lfr_pkg::t_out   o_result
);
    import lfr_pkg::*;

    t_state            cur;
    t_state            nxt;
    t_out              res;
    logic [7:0]        b;
    logic              is_flag;
    logic              ctrl_hit;
    logic [CIDX_W-1:0] ctrl_idx;

    assign b       = i_item.rx_byte;
    assign is_flag = (b == i_cfg.flag_byte);

    // Parallel control table compare; first valid entry wins
    always_comb begin
        ctrl_hit = 1'b0;
        ctrl_idx = '0;
        for (int k = 0; k < CONTROL_ENTRIES; k++) begin
            if (!ctrl_hit && (k < int'(i_cfg.control_count))
                    && (i_cfg.control_byte[k] == b)) begin
                ctrl_hit = 1'b1;
                ctrl_idx = CIDX_W'(k);
            end
        end
    end

    // Apply restart ahead of the byte, then advance the phase
    always_comb begin
        cur = i_state;
        if (i_item.restart) begin
            cur.rx_phase    = PH_START;
            cur.write_index = '0;
        end
        nxt = cur;
        res = '0;

        unique case (cur.rx_phase)
            PH_START: begin
                nxt.write_index = '0;
                if (is_flag) begin
                    res.store_enable = 1'b1;
                    res.store_position = '0;
                    nxt.write_index = WIDX_W'(1);
                    nxt.rx_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                if (!is_flag) begin
                    if (b == i_cfg.address_byte) begin
                        res.store_enable = 1'b1;
                        res.store_position = WIDX_W'(1);
                        nxt.seen_address = b;
                        nxt.write_index = WIDX_W'(2);
                        nxt.rx_phase = PH_ADDR;
                    end else begin
                        nxt.rx_phase = PH_START;
                        nxt.write_index = '0;
                    end
                end
            end
            PH_ADDR: begin
                if (is_flag) begin
                    nxt.rx_phase = PH_FLAG;
                    nxt.write_index = WIDX_W'(1);
                end else if (ctrl_hit) begin
                    res.store_enable = 1'b1;
                    res.store_position = WIDX_W'(2);
                    nxt.seen_control = b;
                    nxt.matched_index = ctrl_idx;
                    nxt.write_index = WIDX_W'(3);
                    nxt.rx_phase = PH_CTRL;
                end else begin
                    nxt.rx_phase = PH_START;
                    nxt.write_index = '0;
                end
            end
            PH_CTRL: begin
                // Header check match has priority over a flag
                if (b == (cur.seen_address ^ cur.seen_control)) begin
                    res.store_enable = 1'b1;
                    res.store_position = WIDX_W'(3);
                    nxt.write_index = HEADER_LEN;
                    nxt.rx_phase = PH_HDR;
                end else if (is_flag) begin
                    nxt.rx_phase = PH_FLAG;
                    nxt.write_index = WIDX_W'(1);
                end else begin
                    nxt.rx_phase = PH_START;
                    nxt.write_index = '0;
                end
            end
            PH_HDR: begin
                if (is_flag) begin
                    res.store_enable = 1'b1;
                    res.store_position = cur.write_index;
                    res.frame_done = 1'b1;
                    if (i_cfg.frame_mode) begin
                        res.payload_length = cur.write_index - HEADER_LEN;
                    end else begin
                        res.control_index = cur.matched_index;
                    end
                    nxt.rx_phase = PH_STOP;
                end else if (!i_cfg.frame_mode) begin
                    nxt.rx_phase = PH_START;
                    nxt.write_index = '0;
                end else if (cur.write_index >= WIDX_LAST) begin
                    // Last slot is kept for the closing flag: drop the frame
                    res.overflow = 1'b1;
                    nxt.rx_phase = PH_START;
                    nxt.write_index = '0;
                end else begin
                    res.store_enable = 1'b1;
                    res.store_position = cur.write_index;
                    nxt.write_index = cur.write_index + WIDX_W'(1);
                end
            end
            PH_STOP: begin
                nxt = cur;
            end
            default: begin
                nxt = cur;
            end
        endcase

        res.rx_state = nxt.rx_phase;
        if (res.store_enable) begin
            res.store_byte = b;
        end
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

@@ tb/link_frame_receiver_tb.sv @@
module link_frame_receiver_tb;

    import lfr_pkg::*;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_PRINTS     = 40;

    // Register index past the end of the map; writes to it must be dropped
    localparam logic [7:0] REG_SPARE = 8'd200;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e  kind;
        logic [7:0] reg_index;
        logic [7:0] value;
        t_in        item;
        bit         typed;
        t_out       want;
    } plan_row_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in        i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out       o_out_data;
    logic       o_cfg_ready;

    // Receiver model: settings and frame tracking state
    t_cfg              link_cfg;
    logic [2:0]        hunt_phase;
    logic [WIDX_W-1:0] fill_pos;
    logic [7:0]        hdr_address;
    logic [7:0]        hdr_control;
    logic [1:0]        ctrl_slot;

    t_out      expected_status[$];
    plan_row_t plan[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int bytes_sent    = 0;
    int frames_closed = 0;
    int overflows     = 0;
    int reg_writes    = 0;
    int stall_cycles  = 0;
    int out_hold      = 0;
    bit gaps_on       = 1'b1;
    bit stall_on      = 1'b1;
    bit quiet         = 1'b0;

    link_frame_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        if (mismatches < MAX_PRINTS) begin
            $display("ERROR result %0d: %s", results_seen, what);
        end
        mismatches++;
    endtask

    task automatic check_field(string name, logic [WIDX_W-1:0] got, logic [WIDX_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Advance the receiver model by one byte and return the status it reports
    function automatic t_out predict_status(t_in it);
        t_out r;
        int   limit;
        int   slot;
        r = '0;
        slot = -1;
        if (it.restart) begin
            hunt_phase = PH_START;
            fill_pos = '0;
        end
        case (hunt_phase)
            PH_START: begin
                fill_pos = '0;
                if (it.rx_byte == link_cfg.flag_byte) begin
                    r.store_enable = 1'b1;
                    fill_pos = WIDX_W'(1);
                    hunt_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                // a repeated opening flag keeps hunting for the address
                if (it.rx_byte != link_cfg.flag_byte) begin
                    if (it.rx_byte == link_cfg.address_byte) begin
                        r.store_enable = 1'b1;
                        r.store_position = WIDX_W'(1);
                        hdr_address = it.rx_byte;
                        fill_pos = WIDX_W'(2);
                        hunt_phase = PH_ADDR;
                    end else begin
                        fill_pos = '0;
                        hunt_phase = PH_START;
                    end
                end
            end
            PH_ADDR: begin
                if (it.rx_byte == link_cfg.flag_byte) begin
                    fill_pos = WIDX_W'(1);
                    hunt_phase = PH_FLAG;
                end else begin
                    // table size caps the count; scan down so the lowest match wins
                    limit = (int'(link_cfg.control_count) > CONTROL_ENTRIES) ?
                            CONTROL_ENTRIES : int'(link_cfg.control_count);
                    for (int k = limit - 1; k >= 0; k--) begin
                        if (link_cfg.control_byte[k] == it.rx_byte) slot = k;
                    end
                    if (slot >= 0) begin
                        r.store_enable = 1'b1;
                        r.store_position = WIDX_W'(2);
                        hdr_control = it.rx_byte;
                        ctrl_slot = 2'(slot);
                        fill_pos = WIDX_W'(3);
                        hunt_phase = PH_CTRL;
                    end else begin
                        fill_pos = '0;
                        hunt_phase = PH_START;
                    end
                end
            end
            PH_CTRL: begin
                // header check wins over a flag of the same value
                if (it.rx_byte == (hdr_address ^ hdr_control)) begin
                    r.store_enable = 1'b1;
                    r.store_position = WIDX_W'(3);
                    fill_pos = HEADER_LEN;
                    hunt_phase = PH_HDR;
                end else if (it.rx_byte == link_cfg.flag_byte) begin
                    fill_pos = WIDX_W'(1);
                    hunt_phase = PH_FLAG;
                end else begin
                    fill_pos = '0;
                    hunt_phase = PH_START;
                end
            end
            PH_HDR: begin
                if (it.rx_byte == link_cfg.flag_byte) begin
                    r.store_enable = 1'b1;
                    r.store_position = fill_pos;
                    r.frame_done = 1'b1;
                    if (link_cfg.frame_mode) begin
                        r.payload_length = fill_pos - HEADER_LEN;
                    end else begin
                        r.control_index = ctrl_slot;
                    end
                    hunt_phase = PH_STOP;
                end else if (!link_cfg.frame_mode) begin
                    fill_pos = '0;
                    hunt_phase = PH_START;
                end else if (fill_pos >= WIDX_LAST) begin
                    // last slot is kept for the closing flag: drop the frame
                    r.overflow = 1'b1;
                    fill_pos = '0;
                    hunt_phase = PH_START;
                end else begin
                    r.store_enable = 1'b1;
                    r.store_position = fill_pos;
                    fill_pos = fill_pos + WIDX_W'(1);
                end
            end
            default: ;
        endcase
        r.rx_state = hunt_phase;
        if (r.store_enable) r.store_byte = it.rx_byte;
        return r;
    endfunction

    function automatic t_out status(logic [2:0] st, logic en, logic [WIDX_W-1:0] pos,
                                    logic [7:0] b, logic dn, logic [WIDX_W-1:0] plen,
                                    logic [1:0] ci, logic ov);
        t_out r;
        r.rx_state       = st;
        r.store_enable   = en;
        r.store_position = pos;
        r.store_byte     = b;
        r.frame_done     = dn;
        r.payload_length = plen;
        r.control_index  = ci;
        r.overflow       = ov;
        return r;
    endfunction

    function automatic plan_row_t byte_row(logic [7:0] b, logic rs);
        plan_row_t r;
        r.kind = ROW_ITEM;
        r.reg_index = '0;
        r.value = '0;
        r.item.rx_byte = b;
        r.item.restart = rs;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic [7:0] b, logic rs, t_out want);
        plan_row_t r;
        r = byte_row(b, rs);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [7:0] idx, logic [7:0] data);
        plan_row_t r;
        r = byte_row(8'h00, 1'b0);
        r.kind = ROW_REG;
        r.reg_index = idx;
        r.value = data;
        return r;
    endfunction

    function automatic logic [7:0] extreme_or_random();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one byte, hold it until the transfer, then record its expected status
    task automatic send_item(t_in it, bit typed, t_out want);
        int   gap;
        t_out pred;
        gap = (!quiet && gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        pred = predict_status(it);
        if (pred.frame_done) frames_closed++;
        if (pred.overflow) overflows++;
        expected_status.push_back(typed ? want : pred);
    endtask

    // Drain all pending results, then write one register
    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            REG_FLAG:    link_cfg.flag_byte = data;
            REG_ADDRESS: link_cfg.address_byte = data;
            REG_MODE:    link_cfg.frame_mode = data[0];
            REG_COUNT:   link_cfg.control_count = data[2:0];
            REG_CTRL_0, REG_CTRL_1, REG_CTRL_2, REG_CTRL_3:
                link_cfg.control_byte[2'(idx - REG_CTRL_0)] = data;
            default: ;
        endcase
    endtask

    task automatic shuffle_settings(bit all_regs, bit long_run);
        logic [7:0] v;
        if (all_regs || $urandom_range(0, 1) == 0) begin
            v = (all_regs || $urandom_range(0, 2) == 0) ? 8'h7E : extreme_or_random();
            write_reg(REG_FLAG, v);
        end
        if (all_regs || $urandom_range(0, 1) == 0) begin
            v = extreme_or_random();
            if (v == link_cfg.flag_byte && $urandom_range(0, 9) != 0) v = ~v;
            write_reg(REG_ADDRESS, v);
        end
        if (all_regs || $urandom_range(0, 1) == 0) begin
            write_reg(REG_MODE, 8'($urandom_range(0, 1)));
        end
        if (all_regs || $urandom_range(0, 1) == 0) begin
            v = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(1, 4));
            write_reg(REG_COUNT, v);
        end
        for (int k = 0; k < CONTROL_ENTRIES; k++) begin
            if (all_regs || $urandom_range(0, 1) == 0) begin
                write_reg(8'(REG_CTRL_0 + k), extreme_or_random());
            end
        end
        // a long frame needs an information frame that can actually open
        if (long_run) begin
            write_reg(REG_MODE, 8'd1);
            write_reg(REG_ADDRESS, link_cfg.flag_byte ^ 8'h5A);
            write_reg(REG_CTRL_0, link_cfg.flag_byte ^ 8'hA5);
            write_reg(REG_COUNT, 8'($urandom_range(1, 4)));
        end
    endtask

    // Build one frame under the current settings, optionally damaged or cut short
    task automatic send_frame(int payload, bit cut, bit clean);
        t_in        seq[$];
        t_in        x;
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] b;
        int         k;
        int         keep;
        x.rx_byte = link_cfg.flag_byte;
        x.restart = clean || $urandom_range(0, 6) != 0;
        seq.push_back(x);
        x.restart = 1'b0;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0) seq.push_back(x);
        a = (clean || $urandom_range(0, 9) != 0) ? link_cfg.address_byte : 8'($urandom);
        k = clean ? 0 : $urandom_range(0, CONTROL_ENTRIES - 1);
        c = (clean || $urandom_range(0, 9) != 0) ? link_cfg.control_byte[2'(k)] : 8'($urandom);
        b = (clean || $urandom_range(0, 9) != 0) ? (a ^ c) : 8'($urandom);
        x.rx_byte = a;
        seq.push_back(x);
        x.rx_byte = c;
        seq.push_back(x);
        x.rx_byte = b;
        seq.push_back(x);
        if (link_cfg.frame_mode || $urandom_range(0, 7) == 0) begin
            repeat (payload) begin
                do b = 8'($urandom); while (b == link_cfg.flag_byte);
                x.rx_byte = b;
                seq.push_back(x);
            end
        end
        x.rx_byte = link_cfg.flag_byte;
        seq.push_back(x);
        if (!clean && $urandom_range(0, 6) == 0) begin
            k = $urandom_range(0, seq.size() - 1);
            x = seq[k];
            x.rx_byte = x.rx_byte ^ (8'd1 << $urandom_range(0, 7));
            seq[k] = x;
        end
        if (cut) begin
            keep = $urandom_range(1, seq.size() - 1);
            while (seq.size() > keep) void'(seq.pop_back());
        end
        foreach (seq[i]) send_item(seq[i], 1'b0, '0);
    endtask

    // Result side: random stall bursts on ready
    always @(posedge i_clk) begin
        if (out_hold != 0) begin
            out_hold = out_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && stall_on && $urandom_range(0, 5) == 0) begin
            out_hold = $urandom_range(1, 5) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each result transfer and watch for a stalled run
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_status.pop_front();
                check_field("rx_state", WIDX_W'(o_out_data.rx_state), WIDX_W'(want.rx_state));
                check_field("store_enable", WIDX_W'(o_out_data.store_enable),
                            WIDX_W'(want.store_enable));
                check_field("store_position", o_out_data.store_position, want.store_position);
                check_field("store_byte", WIDX_W'(o_out_data.store_byte),
                            WIDX_W'(want.store_byte));
                check_field("frame_done", WIDX_W'(o_out_data.frame_done),
                            WIDX_W'(want.frame_done));
                check_field("payload_length", o_out_data.payload_length, want.payload_length);
                check_field("control_index", WIDX_W'(o_out_data.control_index),
                            WIDX_W'(want.control_index));
                check_field("overflow", WIDX_W'(o_out_data.overflow), WIDX_W'(want.overflow));
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int  phase_no;
        bit  long_run;
        t_in x;

        link_cfg.flag_byte     = 8'h7E;
        link_cfg.address_byte  = 8'h03;
        link_cfg.frame_mode    = 1'b0;
        link_cfg.control_count = 3'd1;
        link_cfg.control_byte  = {8'h00, 8'h00, 8'h00, 8'h03};
        hunt_phase  = PH_START;
        fill_pos    = '0;
        hdr_address = '0;
        hdr_control = '0;
        ctrl_slot   = '0;

        // Reset settings: flag 7E, address 03, one control byte 03, header check 00
        plan.push_back(typed_row(8'h7E, 1'b0, status(PH_FLAG, 1, 10'd0, 8'h7E, 0, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'h7E, 1'b0, status(PH_FLAG, 0, 10'd0, 8'h00, 0, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'h03, 1'b0, status(PH_ADDR, 1, 10'd1, 8'h03, 0, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'h7E, 1'b0, status(PH_FLAG, 0, 10'd0, 8'h00, 0, 10'd0, 2'd0, 0)));
        plan.push_back(byte_row(8'h03, 1'b0));
        plan.push_back(byte_row(8'h03, 1'b0));
        plan.push_back(typed_row(8'h7E, 1'b0, status(PH_FLAG, 0, 10'd0, 8'h00, 0, 10'd0, 2'd0, 0)));
        plan.push_back(byte_row(8'h03, 1'b0));
        plan.push_back(byte_row(8'h03, 1'b0));
        plan.push_back(typed_row(8'h00, 1'b0, status(PH_HDR, 1, 10'd3, 8'h00, 0, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'h7E, 1'b0, status(PH_STOP, 1, 10'd4, 8'h7E, 1, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'hFF, 1'b0, status(PH_STOP, 0, 10'd0, 8'h00, 0, 10'd0, 2'd0, 0)));
        plan.push_back(typed_row(8'h7E, 1'b1, status(PH_FLAG, 1, 10'd0, 8'h7E, 0, 10'd0, 2'd0, 0)));
        // Flag 00 equals the header check; count above the table, duplicate entries
        plan.push_back(reg_row(REG_SPARE, 8'hFF));
        plan.push_back(reg_row(REG_FLAG, 8'h00));
        plan.push_back(reg_row(REG_ADDRESS, 8'h12));
        plan.push_back(reg_row(REG_COUNT, 8'd7));
        plan.push_back(reg_row(REG_CTRL_0, 8'hA0));
        plan.push_back(reg_row(REG_CTRL_1, 8'hA1));
        plan.push_back(reg_row(REG_CTRL_2, 8'h12));
        plan.push_back(reg_row(REG_CTRL_3, 8'h12));
        plan.push_back(byte_row(8'h00, 1'b1));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(byte_row(8'h00, 1'b0));
        plan.push_back(typed_row(8'h00, 1'b0, status(PH_STOP, 1, 10'd4, 8'h00, 1, 10'd0, 2'd2, 0)));
        // Empty control table matches nothing
        plan.push_back(reg_row(REG_COUNT, 8'd0));
        plan.push_back(reg_row(REG_MODE, 8'd1));
        plan.push_back(byte_row(8'h00, 1'b1));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(typed_row(8'h12, 1'b0, status(PH_START, 0, 10'd0, 8'h00, 0, 10'd0, 2'd0, 0)));
        // Information frame with no payload
        plan.push_back(reg_row(REG_COUNT, 8'd1));
        plan.push_back(reg_row(REG_CTRL_0, 8'h12));
        plan.push_back(byte_row(8'h00, 1'b1));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(byte_row(8'h00, 1'b0));
        plan.push_back(typed_row(8'h00, 1'b0, status(PH_STOP, 1, 10'd4, 8'h00, 1, 10'd0, 2'd0, 0)));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].reg_index, plan[i].value);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // Random settings, each followed by a batch of mostly well-formed frames
        phase_no = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            long_run = (phase_no == 2);
            shuffle_settings(phase_no == 0, long_run);
            gaps_on = !quiet && $urandom_range(0, 3) != 0;
            stall_on = !quiet && $urandom_range(0, 3) != 0;
            if (long_run) begin
                // one frame runs past the last free slot and is dropped
                send_frame(int'(WIDX_LAST - HEADER_LEN) + 1, 1'b0, 1'b1);
            end
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        x.rx_byte = 8'($urandom);
                        x.restart = ($urandom_range(0, 3) == 0);
                        send_item(x, 1'b0, '0);
                    end
                end
                send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6),
                           $urandom_range(0, 9) == 0, 1'b0);
            end
            phase_no++;
            if (bytes_sent >= RANDOM_ITEMS * 9 / 10) quiet = 1'b1;
        end

        i_in_valid <= 1'b0;
        quiet = 1'b1;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes under %0d settings (%0d register writes)",
                 bytes_sent, phase_no + 4, reg_writes);
        $display("%0d results checked, %0d frames closed, %0d store overflows",
                 results_seen, frames_closed, overflows);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lfr_pkg.sv
rtl/core/lfr_cfg.sv
rtl/core/lfr_step.sv
rtl/core/link_frame_receiver.sv
tb/link_frame_receiver_tb.sv
